### rtl/scan_cycle_supervisor_macros.svh
// scan_cycle_supervisor_macros.svh: assertion macros for the scan cycle supervisor
// each macro expects clk and rst_n to be visible where it is used
`ifndef SCAN_CYCLE_SUPERVISOR_MACROS_SVH
`define SCAN_CYCLE_SUPERVISOR_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SCS_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define SCS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/scs_pkg.sv
// scs_pkg.sv: shared types, codes and helper functions of the scan cycle supervisor
// no dependencies; used by all modules and the testbench
`default_nettype none

package scs_pkg;

    // request types
    localparam logic [1:0] REQ_MODE  = 2'd0;
    localparam logic [1:0] REQ_SCAN  = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // external mode codes
    localparam logic [2:0] MODE_STOP  = 3'd0;
    localparam logic [2:0] MODE_RUN   = 3'd1;
    localparam logic [2:0] MODE_PROG  = 3'd2;
    localparam logic [2:0] MODE_MAINT = 3'd3;
    localparam logic [2:0] MODE_FAULT = 3'd4;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERRUN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WDOG    = 2'd2;

    // configuration reset values in microseconds
    localparam longint TARGET_RESET_US  = 10000;
    localparam longint OVERRUN_RESET_US = 20000;
    localparam longint WDOG_RESET_US    = 100000;

    // internal one-hot operating mode
    typedef enum logic [4:0] {
        MS_STOP  = 5'b00001,
        MS_RUN   = 5'b00010,
        MS_PROG  = 5'b00100,
        MS_MAINT = 5'b01000,
        MS_FAULT = 5'b10000
    } mode_state_t;

    // one-hot mode to external code
    function automatic logic [2:0] mode_code(input mode_state_t m);
        logic [2:0] c;
        case (m)
            MS_STOP:  c = MODE_STOP;
            MS_RUN:   c = MODE_RUN;
            MS_PROG:  c = MODE_PROG;
            MS_MAINT: c = MODE_MAINT;
            MS_FAULT: c = MODE_FAULT;
            default:  c = MODE_STOP;
        endcase
        return c;
    endfunction

    // external code to one-hot mode
    function automatic mode_state_t code_state(input logic [2:0] c);
        mode_state_t m;
        case (c)
            MODE_STOP:  m = MS_STOP;
            MODE_RUN:   m = MS_RUN;
            MODE_PROG:  m = MS_PROG;
            MODE_MAINT: m = MS_MAINT;
            MODE_FAULT: m = MS_FAULT;
            default:    m = MS_STOP;
        endcase
        return m;
    endfunction

    // legal ordinary transitions (fault entry handled separately)
    function automatic logic transition_ok(input mode_state_t from, input logic [2:0] to);
        logic ok;
        case (from)
            MS_STOP:  ok = (to == MODE_RUN) || (to == MODE_PROG) || (to == MODE_MAINT);
            MS_RUN:   ok = (to == MODE_STOP) || (to == MODE_MAINT);
            MS_PROG:  ok = (to == MODE_STOP);
            MS_MAINT: ok = (to == MODE_STOP) || (to == MODE_RUN);
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

### rtl/scs_in_if.sv
// scs_in_if.sv: valid/ready channel carrying one supervisor event
// depends on nothing but its TIME_BITS parameter
`default_nettype none

interface scs_in_if #(parameter int TIME_BITS = 24);
    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [2:0]           requested_mode;
    logic [TIME_BITS-1:0] scan_time_us;
    logic                 program_failed;

    modport source (
        output valid, req_type, requested_mode, scan_time_us, program_failed,
        input  ready
    );
    modport sink (
        input  valid, req_type, requested_mode, scan_time_us, program_failed,
        output ready
    );
endinterface

`default_nettype wire

### rtl/scs_out_if.sv
// scs_out_if.sv: valid/ready channel carrying one supervisor result
// depends on nothing but its TIME_BITS and COUNT_BITS parameters
`default_nettype none

interface scs_out_if #(parameter int TIME_BITS = 24, parameter int COUNT_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic                  status;
    logic [2:0]            mode_now;
    logic                  fault_flag;
    logic                  clear_outputs;
    logic                  watchdog_tripped;
    logic [COUNT_BITS-1:0] run_scans;
    logic [COUNT_BITS-1:0] all_scans;
    logic [COUNT_BITS-1:0] overruns;
    logic [TIME_BITS-1:0]  shortest_us;
    logic [TIME_BITS-1:0]  longest_us;
    logic [TIME_BITS-1:0]  average_us;
    logic [TIME_BITS-1:0]  peak_jitter_us;

    modport source (
        output valid, status, mode_now, fault_flag, clear_outputs, watchdog_tripped,
               run_scans, all_scans, overruns, shortest_us, longest_us, average_us,
               peak_jitter_us,
        input  ready
    );
    modport sink (
        input  valid, status, mode_now, fault_flag, clear_outputs, watchdog_tripped,
               run_scans, all_scans, overruns, shortest_us, longest_us, average_us,
               peak_jitter_us,
        output ready
    );
endinterface

`default_nettype wire

### rtl/scs_avg_update.sv
// scs_avg_update.sv: moving average update, (9*avg + t) / 10 truncated, or t when avg is 0
// divide by ten is a reciprocal multiply with one correction step; uses scs_pkg
`default_nettype none

module scs_avg_update
    import scs_pkg::*;
#(
    parameter int TIME_BITS = 24
)
(
    input  logic [TIME_BITS-1:0] avg,
    input  logic [TIME_BITS-1:0] sample,
    output logic [TIME_BITS-1:0] avg_next
);

    localparam int NUM_W   = TIME_BITS + 4;
    localparam int SHIFT   = NUM_W + 4;
    localparam int RECIP_W = SHIFT - 3;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QUOT_W  = TIME_BITS + 1;

    localparam logic [SHIFT:0]     ONE_SHIFTED = {1'b1, {SHIFT{1'b0}}};
    localparam logic [SHIFT:0]     RECIP_FULL  = ONE_SHIFTED / 10;
    localparam logic [RECIP_W-1:0] RECIP       = RECIP_FULL[RECIP_W-1:0];
    localparam logic [NUM_W-1:0]   TEN         = NUM_W'(10);

    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot_est;
    logic [NUM_W-1:0]  quot_x10;
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;

    // weighted sum 9*avg + t, fits in four extra bits
    assign num = ({4'b0000, avg} << 3) + {4'b0000, avg} + {4'b0000, sample};

    // estimate is exact or one below
    assign prod     = PROD_W'(num) * PROD_W'(RECIP);
    assign quot_est = prod[SHIFT +: QUOT_W];
    assign quot_x10 = (NUM_W'(quot_est) << 3) + (NUM_W'(quot_est) << 1);
    assign rem      = num - quot_x10;
    assign quot     = (rem >= TEN) ? quot_est + QUOT_W'(1) : quot_est;

    // a zero average, as after reset, is seeded with the sample
    assign avg_next = (avg == '0) ? sample : quot[TIME_BITS-1:0];

endmodule

`default_nettype wire

### rtl/scan_cycle_supervisor.sv
// scan_cycle_supervisor.sv: operating mode and scan timing supervisor, top level
// depends on scs_pkg, scs_in_if, scs_out_if, scs_avg_update and the assertion macros
//
// usage:
//   item carries one event: a mode request, a completed scan or a reset to stop.
//   result returns exactly one result per event: status, mode after the event,
//   fault latch, clear_outputs pulse, watchdog flag and the scan statistics.
//   cfg_we/cfg_index/cfg_data write target, overrun limit and watchdog time;
//   index 3 is ignored. write only while no event is in flight.
// timing:
//   an event passes an input register and then lands in the result register.
//   one event per cycle is sustained while results are taken; the bound is
//   the state update through the average divider.
// stall:
//   while result is held by the receiver, one more event waits in the input
//   register; after that item.ready drops until the result is taken.
// reset:
//   rst_n clears both stages, mode goes to stop, counters and statistics to
//   their initial values and the configuration to its defaults.
`default_nettype none

module scan_cycle_supervisor
    import scs_pkg::*;
#(
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]      cfg_data,
    scs_in_if.sink                    item,
    scs_out_if.source                 result
);

`include "scan_cycle_supervisor_macros.svh"

    localparam logic [TIME_BITS-1:0] TARGET_INIT  = TIME_BITS'(TARGET_RESET_US);
    localparam logic [TIME_BITS-1:0] OVERRUN_INIT = TIME_BITS'(OVERRUN_RESET_US);
    localparam logic [TIME_BITS-1:0] WDOG_INIT    = TIME_BITS'(WDOG_RESET_US);

    // configuration
    logic [TIME_BITS-1:0] target_reg;
    logic [TIME_BITS-1:0] overrun_lim_reg;
    logic [TIME_BITS-1:0] wdog_reg;

    // input stage
    logic                 item_valid_reg;
    logic                 item_valid_next;
    logic [1:0]           req_type_reg;
    logic [2:0]           want_reg;
    logic [TIME_BITS-1:0] scan_time_reg;
    logic                 failed_reg;

    // supervisor state
    mode_state_t           mode_reg;
    mode_state_t           mode_next;
    logic                  fault_reg;
    logic                  fault_next;
    logic [COUNT_BITS-1:0] run_cnt_reg;
    logic [COUNT_BITS-1:0] run_cnt_next;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;
    logic [COUNT_BITS-1:0] overrun_cnt_reg;
    logic [COUNT_BITS-1:0] overrun_cnt_next;
    logic [TIME_BITS-1:0]  min_reg;
    logic [TIME_BITS-1:0]  min_next;
    logic [TIME_BITS-1:0]  max_reg;
    logic [TIME_BITS-1:0]  max_next;
    logic [TIME_BITS-1:0]  avg_reg;
    logic [TIME_BITS-1:0]  avg_next;
    logic [TIME_BITS-1:0]  jitter_reg;
    logic [TIME_BITS-1:0]  jitter_next;

    // per-event flags
    logic status_next;
    logic clear_next;
    logic wdog_next;

    // result stage
    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic                 res_status_reg;
    logic                 res_clear_reg;
    logic                 res_wdog_reg;

    logic                 advance;
    logic                 item_xfer;
    logic [TIME_BITS-1:0] avg_calc;
    logic [TIME_BITS-1:0] jit;

    // pipeline control
    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign item_xfer  = item.valid && item.ready;

    always_comb
    begin
        if (item_xfer)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;

        if (advance)
            result_valid_next = 1'b1;
        else if (result.ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= TARGET_INIT;
            overrun_lim_reg <= OVERRUN_INIT;
            wdog_reg        <= WDOG_INIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET:  target_reg      <= cfg_data;
                CFG_OVERRUN: overrun_lim_reg <= cfg_data;
                CFG_WDOG:    wdog_reg        <= cfg_data;
                default:     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            req_type_reg  <= item.req_type;
            want_reg      <= item.requested_mode;
            scan_time_reg <= item.scan_time_us;
            failed_reg    <= item.program_failed;
        end
    end

    // average divider
    scs_avg_update #(
        .TIME_BITS (TIME_BITS)
    ) u_avg (
        .avg      (avg_reg),
        .sample   (scan_time_reg),
        .avg_next (avg_calc)
    );

    // absolute deviation from target
    assign jit = (scan_time_reg >= target_reg) ? scan_time_reg - target_reg
                                               : target_reg - scan_time_reg;

    // event processing
    always_comb
    begin
        mode_next        = mode_reg;
        fault_next       = fault_reg;
        run_cnt_next     = run_cnt_reg;
        total_next       = total_reg;
        overrun_cnt_next = overrun_cnt_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        avg_next         = avg_reg;
        jitter_next      = jitter_reg;
        status_next      = 1'b1;
        clear_next       = 1'b0;
        wdog_next        = 1'b0;

        case (req_type_reg)
            REQ_MODE:
            begin
                if (want_reg == MODE_FAULT)
                begin
                    mode_next   = MS_FAULT;
                    fault_next  = 1'b1;
                    clear_next  = 1'b1;
                    status_next = 1'b0;
                end
                else if (transition_ok(mode_reg, want_reg))
                begin
                    if (mode_reg == MS_STOP && want_reg == MODE_RUN)
                        run_cnt_next = '0;
                    if (mode_reg == MS_RUN && want_reg == MODE_STOP)
                        clear_next = 1'b1;
                    mode_next   = code_state(want_reg);
                    status_next = 1'b0;
                end
            end
            REQ_SCAN:
            begin
                if (mode_reg == MS_RUN || mode_reg == MS_MAINT)
                begin
                    if (failed_reg)
                    begin
                        mode_next  = MS_FAULT;
                        fault_next = 1'b1;
                        clear_next = 1'b1;
                    end
                    else
                    begin
                        run_cnt_next = run_cnt_reg + COUNT_BITS'(1);
                        total_next   = total_reg + COUNT_BITS'(1);
                        if (scan_time_reg < min_reg)
                            min_next = scan_time_reg;
                        if (scan_time_reg > max_reg)
                            max_next = scan_time_reg;
                        avg_next = avg_calc;
                        if (jit > jitter_reg)
                            jitter_next = jit;
                        if (scan_time_reg > wdog_reg)
                        begin
                            mode_next  = MS_FAULT;
                            fault_next = 1'b1;
                            clear_next = 1'b1;
                            wdog_next  = 1'b1;
                        end
                        else
                        begin
                            if (scan_time_reg > overrun_lim_reg)
                                overrun_cnt_next = overrun_cnt_reg + COUNT_BITS'(1);
                            status_next = 1'b0;
                        end
                    end
                end
            end
            REQ_RESET:
            begin
                mode_next   = MS_STOP;
                fault_next  = 1'b0;
                clear_next  = 1'b1;
                status_next = 1'b0;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MS_STOP;
            fault_reg       <= 1'b0;
            run_cnt_reg     <= '0;
            total_reg       <= '0;
            overrun_cnt_reg <= '0;
            min_reg         <= '1;
            max_reg         <= '0;
            avg_reg         <= '0;
            jitter_reg      <= '0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            fault_reg       <= fault_next;
            run_cnt_reg     <= run_cnt_next;
            total_reg       <= total_next;
            overrun_cnt_reg <= overrun_cnt_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
            avg_reg         <= avg_next;
            jitter_reg      <= jitter_next;
        end
    end

    // result register; statistics are read from the state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_status_reg <= status_next;
            res_clear_reg  <= clear_next;
            res_wdog_reg   <= wdog_next;
        end
    end

    // result drive
    assign result.valid            = result_valid_reg;
    assign result.status           = res_status_reg;
    assign result.mode_now         = mode_code(mode_reg);
    assign result.fault_flag       = fault_reg;
    assign result.clear_outputs    = res_clear_reg;
    assign result.watchdog_tripped = res_wdog_reg;
    assign result.run_scans        = run_cnt_reg;
    assign result.all_scans        = total_reg;
    assign result.overruns         = overrun_cnt_reg;
    assign result.shortest_us      = min_reg;
    assign result.longest_us       = max_reg;
    assign result.average_us       = avg_reg;
    assign result.peak_jitter_us   = jitter_reg;

    // checks
    `SCS_ASSERT_HOLDS(a_mode_onehot, $onehot(mode_reg), "mode register not one-hot")
    `SCS_ASSERT_HOLDS(a_fault_latch_mode,
        fault_reg == (mode_reg == MS_FAULT),
        "fault latch out of step with mode")
    `SCS_ASSERT_IMPLIES(a_wdog_clears,
        result_valid_reg && res_wdog_reg,
        res_clear_reg && res_status_reg,
        "watchdog trip without clear and reject")
    `SCS_ASSERT_NEXT(a_item_held,
        item_valid_reg && !advance,
        item_valid_reg,
        "pending event dropped")
    `SCS_ASSERT_NEXT(a_total_step,
        advance,
        (total_reg == $past(total_reg)) || (total_reg == $past(total_reg) + COUNT_BITS'(1)),
        "scan total jumped")

endmodule

`default_nettype wire

### tb/sv/tb_scan_cycle_supervisor.sv
// tb_scan_cycle_supervisor.sv: self-checking testbench of the scan cycle supervisor
// depends on scs_pkg, scs_in_if, scs_out_if and scan_cycle_supervisor from the rtl
// directed mode and scan checks, then random event traffic under several settings
`default_nettype none

module tb_scan_cycle_supervisor;
    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;

    localparam int TIME_BITS    = 24;
    localparam int COUNT_BITS   = 32;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int IDLE_LIMIT   = 200;
    localparam int PHASE_EVENTS = 100;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [2:0]           requested_mode;
        logic [TIME_BITS-1:0] scan_time_us;
        logic                 program_failed;
    } scan_event_t;

    typedef struct packed {
        logic                  status;
        logic [2:0]            mode_now;
        logic                  fault_flag;
        logic                  clear_outputs;
        logic                  watchdog_tripped;
        logic [COUNT_BITS-1:0] run_scans;
        logic [COUNT_BITS-1:0] all_scans;
        logic [COUNT_BITS-1:0] overruns;
        logic [TIME_BITS-1:0]  shortest_us;
        logic [TIME_BITS-1:0]  longest_us;
        logic [TIME_BITS-1:0]  average_us;
        logic [TIME_BITS-1:0]  peak_jitter_us;
    } supervisor_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [TIME_BITS-1:0]      cfg_data;

    scs_in_if  #(.TIME_BITS(TIME_BITS)) item_if ();
    scs_out_if #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) res_if ();

    scan_cycle_supervisor #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (res_if)
    );

    // predicted supervisor state and settings
    logic [2:0]            mode_q;
    logic                  fault_q;
    logic [COUNT_BITS-1:0] run_cnt;
    logic [COUNT_BITS-1:0] total_cnt;
    logic [COUNT_BITS-1:0] overrun_cnt;
    logic [TIME_BITS-1:0]  min_t;
    logic [TIME_BITS-1:0]  max_t;
    logic [TIME_BITS-1:0]  avg_t;
    logic [TIME_BITS-1:0]  jitter_t;
    logic [TIME_BITS-1:0]  cfg_target;
    logic [TIME_BITS-1:0]  cfg_overrun;
    logic [TIME_BITS-1:0]  cfg_wdog;

    supervisor_result_t expected_results[$];
    int                 error_count;
    int                 quiet_cycles;
    bit                 pace_on;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // apply one event to the predicted state and return the result it gives
    function automatic supervisor_result_t supervise_event(input scan_event_t ev);
        supervisor_result_t   res;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] dev;
        logic [2:0]           want;
        logic                 step_ok;
        res = '0;
        res.status = 1'b1;
        t = ev.scan_time_us;
        want = ev.requested_mode;
        case (ev.req_type)
            REQ_MODE:
            begin
                case (mode_q)
                    MODE_STOP:  step_ok = (want == MODE_RUN) || (want == MODE_PROG) ||
                                          (want == MODE_MAINT);
                    MODE_RUN:   step_ok = (want == MODE_STOP) || (want == MODE_MAINT);
                    MODE_PROG:  step_ok = (want == MODE_STOP);
                    MODE_MAINT: step_ok = (want == MODE_STOP) || (want == MODE_RUN);
                    default:    step_ok = 1'b0;
                endcase
                if (want == MODE_FAULT)
                begin
                    mode_q = MODE_FAULT;
                    fault_q = 1'b1;
                    res.clear_outputs = 1'b1;
                    res.status = 1'b0;
                end
                else if (step_ok)
                begin
                    if (mode_q == MODE_STOP && want == MODE_RUN)
                        run_cnt = '0;
                    if (mode_q == MODE_RUN && want == MODE_STOP)
                        res.clear_outputs = 1'b1;
                    mode_q = want;
                    res.status = 1'b0;
                end
            end
            REQ_SCAN:
            begin
                if (mode_q == MODE_RUN || mode_q == MODE_MAINT)
                begin
                    if (ev.program_failed)
                    begin
                        mode_q = MODE_FAULT;
                        fault_q = 1'b1;
                        res.clear_outputs = 1'b1;
                    end
                    else
                    begin
                        run_cnt = run_cnt + 1'b1;
                        total_cnt = total_cnt + 1'b1;
                        if (t < min_t)
                            min_t = t;
                        if (t > max_t)
                            max_t = t;
                        if (avg_t == '0)
                            avg_t = t;
                        else
                            avg_t = TIME_BITS'((32'(avg_t) * 9 + 32'(t)) / 10);
                        dev = (t >= cfg_target) ? t - cfg_target : cfg_target - t;
                        if (dev > jitter_t)
                            jitter_t = dev;
                        if (t > cfg_wdog)
                        begin
                            mode_q = MODE_FAULT;
                            fault_q = 1'b1;
                            res.clear_outputs = 1'b1;
                            res.watchdog_tripped = 1'b1;
                        end
                        else
                        begin
                            if (t > cfg_overrun)
                                overrun_cnt = overrun_cnt + 1'b1;
                            res.status = 1'b0;
                        end
                    end
                end
            end
            REQ_RESET:
            begin
                mode_q = MODE_STOP;
                fault_q = 1'b0;
                res.clear_outputs = 1'b1;
                res.status = 1'b0;
            end
            default: ;
        endcase
        res.mode_now = mode_q;
        res.fault_flag = fault_q;
        res.run_scans = run_cnt;
        res.all_scans = total_cnt;
        res.overruns = overrun_cnt;
        res.shortest_us = min_t;
        res.longest_us = max_t;
        res.average_us = avg_t;
        res.peak_jitter_us = jitter_t;
        return res;
    endfunction

    function automatic scan_event_t make_event(input logic [1:0] req, input logic [2:0] code,
                                               input logic [TIME_BITS-1:0] t,
                                               input logic failed);
        scan_event_t ev;
        ev.req_type = req;
        ev.requested_mode = code;
        ev.scan_time_us = t;
        ev.program_failed = failed;
        return ev;
    endfunction

    // scan time around the current thresholds, with some far outliers
    function automatic logic [TIME_BITS-1:0] pick_scan_time();
        int unsigned r;
        longint      v;
        r = $urandom_range(0, 99);
        if (r < 50)
            v = longint'(cfg_target) + longint'($urandom_range(0, 4000)) - 2000;
        else if (r < 65)
            v = (cfg_wdog > cfg_overrun) ? $urandom_range(32'(cfg_overrun) + 1, cfg_wdog)
                                         : cfg_wdog;
        else if (r < 73)
            v = (cfg_wdog != TIME_MAX) ? $urandom_range(32'(cfg_wdog) + 1, TIME_MAX)
                                       : TIME_MAX;
        else if (r < 83)
            v = $urandom_range(0, 64);
        else if (r < 91)
        begin
            case ($urandom_range(0, 3))
                0:       v = cfg_target;
                1:       v = cfg_overrun;
                2:       v = cfg_wdog;
                default: v = TIME_MAX;
            endcase
        end
        else
            v = $urandom & TIME_MAX;
        if (v < 0)
            v = 0;
        if (v > TIME_MAX)
            v = TIME_MAX;
        return TIME_BITS'(v);
    endfunction

    // mostly well-formed traffic steered by the predicted mode, plus some noise
    function automatic scan_event_t draw_event();
        scan_event_t ev;
        int unsigned r;
        ev.req_type = REQ_MODE;
        ev.requested_mode = 3'($urandom_range(0, 4));
        ev.scan_time_us = TIME_BITS'($urandom);
        ev.program_failed = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            ev.req_type = 2'($urandom_range(0, 3));
            ev.requested_mode = 3'($urandom_range(0, 7));
            return ev;
        end
        case (mode_q)
            MODE_RUN, MODE_MAINT:
            begin
                if (r < 82)
                begin
                    ev.req_type = REQ_SCAN;
                    ev.scan_time_us = pick_scan_time();
                    ev.program_failed = ($urandom_range(0, 49) == 0);
                end
                else if (r < 86)
                    ev.req_type = REQ_RESET;
            end
            MODE_STOP:
            begin
                if (r < 60)
                    ev.requested_mode = MODE_RUN;
                else if (r < 75)
                    ev.requested_mode = MODE_MAINT;
                else if (r < 85)
                    ev.requested_mode = MODE_PROG;
            end
            MODE_PROG:
            begin
                if (r < 70)
                    ev.requested_mode = MODE_STOP;
            end
            default:
            begin
                if (r < 75)
                    ev.req_type = REQ_RESET;
            end
        endcase
        return ev;
    endfunction

    // one event transfer; the expectation is formed when it is accepted
    task automatic send_event(input scan_event_t ev);
        int gap;
        gap = pace_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.req_type <= ev.req_type;
        item_if.requested_mode <= ev.requested_mode;
        item_if.scan_time_us <= ev.scan_time_us;
        item_if.program_failed <= ev.program_failed;
        item_if.valid <= 1'b1;
        do @(posedge clk); while (!item_if.ready);
        expected_results.push_back(supervise_event(ev));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_events();
        item_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [TIME_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_TARGET:  cfg_target = val;
            CFG_OVERRUN: cfg_overrun = val;
            CFG_WDOG:    cfg_wdog = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [TIME_BITS-1:0] target,
                                  input logic [TIME_BITS-1:0] overrun,
                                  input logic [TIME_BITS-1:0] wdog);
        drain_events();
        write_reg(CFG_TARGET, target);
        write_reg(CFG_OVERRUN, overrun);
        write_reg(CFG_WDOG, wdog);
    endtask

    // transition table, rejected codes and fault entry
    task automatic test_mode_table();
        pace_on = 1'b1;
        send_event(make_event(REQ_MODE, MODE_STOP, '0, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, 24'd500, 1'b0));
        send_event(make_event(REQ_MODE, MODE_PROG, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_RUN, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_STOP, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_MAINT, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_RUN, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_STOP, '0, 1'b0));
        send_event(make_event(REQ_MODE, 3'd7, TIME_MAX, 1'b1));
        send_event(make_event(REQ_NONE, MODE_RUN, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_FAULT, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_FAULT, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_RUN, '0, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, 24'd700, 1'b0));
        drain_events();
    endtask

    // statistics, overrun, watchdog trip and program failure at the default settings
    task automatic test_scan_statistics();
        pace_on = 1'b0;
        send_event(make_event(REQ_RESET, MODE_STOP, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_RUN, '0, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, 24'd10000, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, 24'd0, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, 24'd20001, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, 24'd100000, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, TIME_MAX, 1'b0));
        send_event(make_event(REQ_RESET, MODE_STOP, '0, 1'b0));
        send_event(make_event(REQ_MODE, MODE_MAINT, '0, 1'b0));
        send_event(make_event(REQ_SCAN, MODE_STOP, 24'd5, 1'b1));
        send_event(make_event(REQ_RESET, MODE_STOP, '0, 1'b0));
        drain_events();
    endtask

    // random traffic under default, extreme and random settings
    task automatic test_random_traffic();
        int unsigned a;
        int unsigned b;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_settings(TIME_BITS'(TARGET_RESET_US), TIME_BITS'(OVERRUN_RESET_US),
                                  TIME_BITS'(WDOG_RESET_US));
                1: apply_settings('0, '0, '0);
                2: apply_settings(TIME_MAX, TIME_MAX, TIME_MAX);
                3:
                begin
                    a = $urandom_range(0, 50000);
                    b = a + $urandom_range(0, 50000);
                    apply_settings(TIME_BITS'(a), TIME_BITS'(b),
                                   TIME_BITS'(b + $urandom_range(0, 200000)));
                end
                4: apply_settings(TIME_BITS'($urandom), TIME_BITS'($urandom),
                                  TIME_BITS'($urandom));
                default:
                begin
                    a = $urandom_range(50, 200);
                    b = a + $urandom_range(0, 100);
                    apply_settings(TIME_BITS'(a), TIME_BITS'(b),
                                   TIME_BITS'(b + $urandom_range(0, 400)));
                end
            endcase
            for (int i = 0; i < PHASE_EVENTS; i++)
            begin
                // stretches with and without idle cycles on both sides
                if (i % 25 == 0)
                    pace_on = ($urandom_range(0, 3) != 0);
                send_event(draw_event());
            end
        end
        drain_events();
    endtask

    function automatic void check_field(input string field_name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field_name, want, got);
        end
    endfunction

    // result side: random stalls and a check of every transfer
    initial
    begin
        supervisor_result_t want;
        int                 stall;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pace_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result transfer with nothing expected, %s %0d",
                         $time, "expected none, got mode", res_if.mode_now);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, res_if.status);
                check_field("mode_now", want.mode_now, res_if.mode_now);
                check_field("fault_flag", want.fault_flag, res_if.fault_flag);
                check_field("clear_outputs", want.clear_outputs, res_if.clear_outputs);
                check_field("watchdog_tripped", want.watchdog_tripped, res_if.watchdog_tripped);
                check_field("run_scans", want.run_scans, res_if.run_scans);
                check_field("all_scans", want.all_scans, res_if.all_scans);
                check_field("overruns", want.overruns, res_if.overruns);
                check_field("shortest_us", want.shortest_us, res_if.shortest_us);
                check_field("longest_us", want.longest_us, res_if.longest_us);
                check_field("average_us", want.average_us, res_if.average_us);
                check_field("peak_jitter_us", want.peak_jitter_us, res_if.peak_jitter_us);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // main sequence
    initial
    begin
        error_count = 0;
        pace_on = 1'b1;
        mode_q = MODE_STOP;
        fault_q = 1'b0;
        run_cnt = '0;
        total_cnt = '0;
        overrun_cnt = '0;
        min_t = TIME_MAX;
        max_t = '0;
        avg_t = '0;
        jitter_t = '0;
        cfg_target = TIME_BITS'(TARGET_RESET_US);
        cfg_overrun = TIME_BITS'(OVERRUN_RESET_US);
        cfg_wdog = TIME_BITS'(WDOG_RESET_US);
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        item_if.valid <= 1'b0;
        item_if.req_type <= REQ_MODE;
        item_if.requested_mode <= MODE_STOP;
        item_if.scan_time_us <= '0;
        item_if.program_failed <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_mode_table();
        test_scan_statistics();
        test_random_traffic();

        // let any stray result show up before the verdict
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

### scan_cycle_supervisor.f
+incdir+rtl
rtl/scs_pkg.sv
rtl/scs_in_if.sv
rtl/scs_out_if.sv
rtl/scs_avg_update.sv
rtl/scan_cycle_supervisor.sv
tb/sv/tb_scan_cycle_supervisor.sv
